// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion wrappers, sampled on the rising clock edge
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked every cycle outside reset
`define ASSERT_CLK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// condition that must never be seen outside reset
`define ASSERT_NEVER(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) !(cond)) else $error(msg);

`endif

// ===== src/tdt_pkg.sv =====
// ----------------------------------------------------------------------------
// tdt_pkg
// shared constants and types of the task delay tick table
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tdt_pkg;

   localparam int TASKS      = 16;
   localparam int PROCESSORS = 2;

   localparam int OPCODE_W   = 2;
   localparam int CPU_W      = 1;
   localparam int TASK_W     = 4;
   localparam int VALUE_W    = 32;
   localparam int TIME_W     = 64;
   // table index, same width as the task field
   localparam int TASK_IDX_W = TASK_W;
   // suspended flag plus delay counter
   localparam int SCHED_W    = VALUE_W + 1;

   typedef enum logic [OPCODE_W-1:0] {
      OP_TICK     = 2'd0,
      OP_WAIT     = 2'd1,
      OP_DEADLINE = 2'd2
   } opcode_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WALK,
      ST_FLUSH
   } walk_state_type;

   typedef struct packed {
      logic               suspended;
      logic [VALUE_W-1:0] delay_left;
   } sched_word_type;

   typedef struct packed {
      logic [TASK_W-1:0] woken_task;
      logic [CPU_W-1:0]  queue_cpu;
      logic [TIME_W-1:0] absolute_deadline;
   } result_type;

   typedef struct packed {
      logic       push;
      logic       flush;
      result_type result;
   } out_ctl_type;

   typedef struct packed {
      logic stall;
   } out_status_type;

endpackage

// ===== src/tdt_if.sv =====
// ----------------------------------------------------------------------------
// tdt channel interfaces
// valid/ready channels for requests and wake results
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface tdt_req_if;
   logic                         valid;
   logic                         ready;
   logic [tdt_pkg::OPCODE_W-1:0] opcode;
   logic [tdt_pkg::CPU_W-1:0]    cpu_id;
   logic [tdt_pkg::TASK_W-1:0]   task_id;
   logic [tdt_pkg::VALUE_W-1:0]  value;

   modport source (output valid, output opcode, output cpu_id, output task_id,
                   output value, input ready);
   modport sink   (input valid, input opcode, input cpu_id, input task_id,
                   input value, output ready);
endinterface

interface tdt_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [tdt_pkg::TASK_W-1:0]  woken_task;
   logic [tdt_pkg::CPU_W-1:0]   queue_cpu;
   logic [tdt_pkg::TIME_W-1:0]  absolute_deadline;
   logic                        last;

   modport source (output valid, output woken_task, output queue_cpu,
                   output absolute_deadline, output last, input ready);
   modport sink   (input valid, input woken_task, input queue_cpu,
                   input absolute_deadline, input last, output ready);
endinterface

// ===== src/tdt_ram.sv =====
// ----------------------------------------------------------------------------
// tdt_ram
// one write, one read port ram with registered read and per-entry valid bits
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tdt_ram #(
   parameter int DATA_W = 32,
   parameter int DEPTH  = 16
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [DATA_W-1:0]                         wr_data,
   input  logic                                      rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [DATA_W-1:0]                         rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DEPTH-1:0]  valid_ff;
   logic [DATA_W-1:0] rd_data_ff;

   // never-written entries read as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= valid_ff[rd_addr] ? mem[rd_addr] : '0;
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/tdt_out_stage.sv =====
// ----------------------------------------------------------------------------
// tdt_out_stage
// holds back one wake result so the last of a tick can be marked
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tdt_out_stage (
   input  logic                    clock,
   input  logic                    reset,
   input  tdt_pkg::out_ctl_type    ctl,
   output tdt_pkg::out_status_type status,
   tdt_rsp_if.source               rsp_bus
);

   logic                 pend_valid_ff, pend_valid_in;
   tdt_pkg::result_type  pend_ff;
   logic                 out_valid_ff, out_valid_in;
   tdt_pkg::result_type  out_ff;
   logic                 out_last_ff;
   logic                 out_free;
   logic                 move;

   assign out_free     = !out_valid_ff || rsp_bus.ready;
   assign move         = (ctl.push || ctl.flush) && pend_valid_ff && out_free;
   assign status.stall = (ctl.push || ctl.flush) && pend_valid_ff && !out_free;

   always_comb begin
      out_valid_in = out_valid_ff;
      if (move) begin
         out_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_comb begin
      pend_valid_in = pend_valid_ff;
      if (ctl.push && !status.stall) begin
         pend_valid_in = 1'b1;
      end else if (ctl.flush && move) begin
         pend_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.push && !status.stall) begin
         pend_ff <= ctl.result;
      end
      if (move) begin
         out_ff      <= pend_ff;
         out_last_ff <= ctl.flush;
      end
   end

   assign rsp_bus.valid             = out_valid_ff;
   assign rsp_bus.woken_task        = out_ff.woken_task;
   assign rsp_bus.queue_cpu         = out_ff.queue_cpu;
   assign rsp_bus.absolute_deadline = out_ff.absolute_deadline;
   assign rsp_bus.last              = out_last_ff;

endmodule

// ===== src/task_delay_tick_table_unit.sv =====
// ----------------------------------------------------------------------------
// task_delay_tick_table_unit
// per-task delay table with per-processor time counters and wake results
// ----------------------------------------------------------------------------
//  channel   dir  payload                                        handshake
//  req_bus   in   opcode, cpu_id, task_id, value                 valid/ready
//  rsp_bus   out  woken_task, queue_cpu, absolute_deadline, last valid/ready
//
//  wait and deadline requests are written straight in from idle
//  a tick: accept, then one table entry per cycle over 16 entries while the
//  result channel does not stall, through the registered read port of the
//  task ram, then a flush state marks and releases the held-back last result
//  reset clears the ram valid bits at once, so no clearing pass is needed
//  a stalled result channel holds the walk on its current entry
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module task_delay_tick_table_unit (
   input  logic    clock,
   input  logic    reset,
   tdt_req_if.sink   req_bus,
   tdt_rsp_if.source rsp_bus
);

   // fsm and walk state
   tdt_pkg::walk_state_type          state_ff, state_in;
   logic [tdt_pkg::TASK_IDX_W-1:0]   walk_idx_ff, walk_idx_in;
   logic [tdt_pkg::CPU_W-1:0]        tick_cpu_ff;
   logic [tdt_pkg::TIME_W-1:0]       time_ff [tdt_pkg::PROCESSORS];

   // request decode
   logic                             req_xfer;
   logic                             tick_go;
   logic                             wait_go;
   logic                             deadline_go;
   logic                             task_ok;

   // ram ports
   logic                             sched_wr_en;
   logic [tdt_pkg::TASK_IDX_W-1:0]   sched_wr_addr;
   tdt_pkg::sched_word_type          sched_wr_word;
   tdt_pkg::sched_word_type          sched_rd_word;
   logic [tdt_pkg::SCHED_W-1:0]      sched_rd_data;
   logic                             dl_wr_en;
   logic [tdt_pkg::VALUE_W-1:0]      dl_rd_data;
   logic                             rd_en;
   logic [tdt_pkg::TASK_IDX_W-1:0]   rd_addr;

   // entry processing
   logic                             entry_active;
   logic [tdt_pkg::VALUE_W-1:0]      delay_dec;
   logic                             entry_wake;
   logic                             last_idx;
   logic [tdt_pkg::TIME_W-1:0]       time_now;

   tdt_pkg::out_ctl_type             out_ctl;
   tdt_pkg::out_status_type          out_status;

   assign req_bus.ready = (state_ff == tdt_pkg::ST_IDLE);
   assign req_xfer      = req_bus.valid && req_bus.ready;
   assign task_ok       = int'(req_bus.task_id) < tdt_pkg::TASKS;

   // a tick from a processor outside the table advances nothing
   assign tick_go     = req_xfer && (req_bus.opcode == tdt_pkg::OP_TICK)
                        && (int'(req_bus.cpu_id) < tdt_pkg::PROCESSORS);
   // a zero-tick wait leaves the task alone
   assign wait_go     = req_xfer && (req_bus.opcode == tdt_pkg::OP_WAIT)
                        && task_ok && (req_bus.value != '0);
   assign deadline_go = req_xfer && (req_bus.opcode == tdt_pkg::OP_DEADLINE) && task_ok;

   // entry under the walk, from the registered read port
   assign sched_rd_word = tdt_pkg::sched_word_type'(sched_rd_data);
   assign entry_active  = sched_rd_word.suspended && (sched_rd_word.delay_left != '0);
   assign delay_dec     = sched_rd_word.delay_left - 1'b1;
   assign entry_wake    = entry_active && (delay_dec == '0);
   assign last_idx      = (walk_idx_ff == tdt_pkg::TASK_IDX_W'(tdt_pkg::TASKS - 1));
   assign time_now      = time_ff[tick_cpu_ff];

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         tdt_pkg::ST_IDLE: begin
            if (tick_go) state_in = tdt_pkg::ST_WALK;
         end
         tdt_pkg::ST_WALK: begin
            if (!out_status.stall && last_idx) state_in = tdt_pkg::ST_FLUSH;
         end
         tdt_pkg::ST_FLUSH: begin
            if (!out_status.stall) state_in = tdt_pkg::ST_IDLE;
         end
         default: state_in = tdt_pkg::ST_IDLE;
      endcase
   end

   // outputs of the fsm: ram ports and result control
   always_comb begin
      sched_wr_en   = 1'b0;
      sched_wr_addr = req_bus.task_id;
      sched_wr_word = '{suspended: 1'b1, delay_left: req_bus.value};
      dl_wr_en      = 1'b0;
      rd_en         = 1'b0;
      rd_addr       = '0;
      out_ctl       = '0;
      out_ctl.result.woken_task        = tdt_pkg::TASK_W'(walk_idx_ff);
      out_ctl.result.queue_cpu         = tick_cpu_ff;
      out_ctl.result.absolute_deadline = time_now + tdt_pkg::TIME_W'(dl_rd_data);
      unique case (state_ff)
         tdt_pkg::ST_IDLE: begin
            sched_wr_en = wait_go;
            dl_wr_en    = deadline_go;
            // prefetch entry zero for the walk
            rd_en       = tick_go;
         end
         tdt_pkg::ST_WALK: begin
            out_ctl.push  = entry_wake;
            sched_wr_en   = entry_active && !out_status.stall;
            sched_wr_addr = walk_idx_ff;
            sched_wr_word = '{suspended: !entry_wake, delay_left: delay_dec};
            // next entry read while this one is written back
            rd_en         = !out_status.stall && !last_idx;
            rd_addr       = walk_idx_ff + 1'b1;
         end
         tdt_pkg::ST_FLUSH: begin
            out_ctl.flush = 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      walk_idx_in = walk_idx_ff;
      if (tick_go) begin
         walk_idx_in = '0;
      end else if ((state_ff == tdt_pkg::ST_WALK) && !out_status.stall) begin
         walk_idx_in = walk_idx_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= tdt_pkg::ST_IDLE;
         walk_idx_ff <= '0;
         tick_cpu_ff <= '0;
         for (int i = 0; i < tdt_pkg::PROCESSORS; i++) begin
            time_ff[i] <= '0;
         end
      end else begin
         state_ff    <= state_in;
         walk_idx_ff <= walk_idx_in;
         if (tick_go) begin
            tick_cpu_ff             <= req_bus.cpu_id;
            time_ff[req_bus.cpu_id] <= time_ff[req_bus.cpu_id] + 1'b1;
         end
      end
   end

   // suspended flag and delay counter per task
   tdt_ram #(
      .DATA_W (tdt_pkg::SCHED_W),
      .DEPTH  (tdt_pkg::TASKS)
   ) u_sched_ram (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (sched_wr_en),
      .wr_addr (sched_wr_addr),
      .wr_data (sched_wr_word),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (sched_rd_data)
   );

   // relative deadline per task
   tdt_ram #(
      .DATA_W (tdt_pkg::VALUE_W),
      .DEPTH  (tdt_pkg::TASKS)
   ) u_deadline_ram (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (dl_wr_en),
      .wr_addr (req_bus.task_id),
      .wr_data (req_bus.value),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (dl_rd_data)
   );

   // held-back result and output register
   tdt_out_stage u_out_stage (
      .clock   (clock),
      .reset   (reset),
      .ctl     (out_ctl),
      .status  (out_status),
      .rsp_bus (rsp_bus)
   );

   // assertions
   `ASSERT_CLK(a_tick_starts_walk, tick_go |=> (state_ff == tdt_pkg::ST_WALK),
      "accepted tick did not start the walk")
   `ASSERT_CLK(a_stall_holds_walk,
      (out_status.stall && (state_ff == tdt_pkg::ST_WALK)) |=> $stable(walk_idx_ff),
      "walk moved on while the result side was stalled")
   `ASSERT_NEVER(a_push_outside_walk, out_ctl.push && (state_ff != tdt_pkg::ST_WALK),
      "wake result pushed outside a walk")
   `ASSERT_NEVER(a_write_collides_read,
      sched_wr_en && rd_en && (sched_wr_addr == rd_addr),
      "write back and prefetch hit the same entry")

endmodule
